@@ design/ppam_pkg.sv @@
// shared types and constants for the perspective plane address map
package ppam_pkg;

   localparam int PLANE_WIDTH  = 180;
   localparam int PLANE_HEIGHT = 120;
   localparam int IMAGE_WIDTH  = 640;
   localparam int IMAGE_HEIGHT = 480;

   localparam int COEF_W    = 32;
   localparam int PIX_W     = 12;
   localparam int TEX_W     = 8;
   localparam int NUM_COEF  = 8;
   localparam int IDX_W     = 3;
   localparam int PROD_W    = COEF_W + PIX_W + 1;
   localparam int SUM_W     = 48;
   localparam int FRAC_BITS = 30;
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int DIV_LAT   = DIV_STEPS + 1;

   typedef enum logic [IDX_W-1:0] {
      REG_XU = 3'd0,
      REG_XV = 3'd1,
      REG_X0 = 3'd2,
      REG_YU = 3'd3,
      REG_YV = 3'd4,
      REG_Y0 = 3'd5,
      REG_DU = 3'd6,
      REG_DV = 3'd7
   } reg_index_type;

   typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_set_type;

   // control that travels alongside the data
   typedef struct packed {
      logic valid;
      logic in_img;
      logic den_ok;
   } side_type;

   // operands handed from the multiply-add stages to the dividers
   typedef struct packed {
      side_type         side;
      logic             neg_x;
      logic             sat_x;
      logic [SUM_W-1:0] mag_x;
      logic             neg_y;
      logic             sat_y;
      logic [SUM_W-1:0] mag_y;
      logic [SUM_W-1:0] den;
   } prep_type;

endpackage

@@ design/ppam_mac.sv @@
// multiply-add stages: numerators, denominator and divider operand set-up
module ppam_mac
   import ppam_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [PIX_W-1:0]  pixel_u,
   input  logic [PIX_W-1:0]  pixel_v,
   input  coef_set_type      coefs,
   output prep_type          prep
);

   logic signed [PROD_W-1:0] p_xu_ff, p_xv_ff, p_yu_ff, p_yv_ff, p_du_ff, p_dv_ff;
   logic                     v1_ff, img1_ff;
   logic signed [SUM_W-1:0]  nx_ff, ny_ff, den_ff;
   logic                     v2_ff, img2_ff;
   prep_type                 prep_ff, prep_in;
   logic signed [PIX_W:0]    u_s, v_s;
   logic                     img_in;

   assign u_s    = $signed({1'b0, pixel_u});
   assign v_s    = $signed({1'b0, pixel_v});
   assign img_in = ({1'b0, pixel_u} < (PIX_W+1)'(IMAGE_WIDTH)) &&
                   ({1'b0, pixel_v} < (PIX_W+1)'(IMAGE_HEIGHT));

   // stage 1: products
   always_ff @(posedge clock) begin
      p_xu_ff <= $signed(coefs[REG_XU]) * u_s;
      p_xv_ff <= $signed(coefs[REG_XV]) * v_s;
      p_yu_ff <= $signed(coefs[REG_YU]) * u_s;
      p_yv_ff <= $signed(coefs[REG_YV]) * v_s;
      p_du_ff <= $signed(coefs[REG_DU]) * u_s;
      p_dv_ff <= $signed(coefs[REG_DV]) * v_s;
      img1_ff <= img_in;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   // stage 2: sums
   always_ff @(posedge clock) begin
      nx_ff   <= SUM_W'(p_xu_ff) + SUM_W'(p_xv_ff) + SUM_W'($signed(coefs[REG_X0]));
      ny_ff   <= SUM_W'(p_yu_ff) + SUM_W'(p_yv_ff) + SUM_W'($signed(coefs[REG_Y0]));
      den_ff  <= SUM_W'(p_du_ff) + SUM_W'(p_dv_ff) + (SUM_W'(1) << FRAC_BITS);
      img2_ff <= img1_ff;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // stage 3: magnitudes and saturation test against twice the denominator
   always_comb begin
      prep_in.side.valid  = v2_ff;
      prep_in.side.in_img = img2_ff;
      prep_in.side.den_ok = !den_ff[SUM_W-1] && (den_ff != '0);
      prep_in.den         = den_ff;
      prep_in.neg_x       = nx_ff[SUM_W-1];
      prep_in.mag_x       = nx_ff[SUM_W-1] ? SUM_W'(-nx_ff) : SUM_W'(nx_ff);
      prep_in.neg_y       = ny_ff[SUM_W-1];
      prep_in.mag_y       = ny_ff[SUM_W-1] ? SUM_W'(-ny_ff) : SUM_W'(ny_ff);
      prep_in.sat_x       = prep_in.mag_x >= {den_ff[SUM_W-2:0], 1'b0};
      prep_in.sat_y       = prep_in.mag_y >= {den_ff[SUM_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
      if (reset) begin
         prep_ff.side.valid <= 1'b0;
      end
   end

   assign prep = prep_ff;

endmodule

@@ design/ppam_div.sv @@
// pipelined restoring divider, one quotient bit per stage, floor and saturation
module ppam_div
   import ppam_pkg::*;
(
   input  logic                     clock,
   input  logic [SUM_W-1:0]         mag,
   input  logic                     neg,
   input  logic                     sat,
   input  logic [SUM_W-1:0]         den,
   output logic signed [COEF_W-1:0] quot
);

   logic [SUM_W-1:0]     r_ff   [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS];
   logic [SUM_W-1:0]     den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] neg_ff, sat_ff;

   logic [SUM_W-1:0]     cand_w [DIV_STEPS];
   logic [SUM_W-1:0]     dprev_w[DIV_STEPS];
   logic [DIV_STEPS-1:0] qprev_w[DIV_STEPS];
   logic [DIV_STEPS-1:0] nprev_w, sprev_w;

   logic [DIV_STEPS-1:0] q_fin;
   logic                 r_nz;
   logic [COEF_W-1:0]    quot_ff, quot_in;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic ge;
      // operands from the previous stage
      if (k == 0) begin : g_first
         assign cand_w[k]  = mag;
         assign dprev_w[k] = den;
         assign qprev_w[k] = '0;
         assign nprev_w[k] = neg;
         assign sprev_w[k] = sat;
      end else begin : g_next
         assign cand_w[k]  = {r_ff[k-1][SUM_W-2:0], 1'b0};
         assign dprev_w[k] = den_ff[k-1];
         assign qprev_w[k] = q_ff[k-1];
         assign nprev_w[k] = neg_ff[k-1];
         assign sprev_w[k] = sat_ff[k-1];
      end
      assign ge = cand_w[k] >= dprev_w[k];

      // one trial subtract
      always_ff @(posedge clock) begin
         r_ff[k]   <= ge ? (cand_w[k] - dprev_w[k]) : cand_w[k];
         q_ff[k]   <= {qprev_w[k][DIV_STEPS-2:0], ge};
         den_ff[k] <= dprev_w[k];
         neg_ff[k] <= nprev_w[k];
         sat_ff[k] <= sprev_w[k];
      end
   end

   // sign, floor correction and clamp
   assign q_fin = q_ff[DIV_STEPS-1];
   assign r_nz  = |r_ff[DIV_STEPS-1];

   always_comb begin
      if (sat_ff[DIV_STEPS-1]) begin
         quot_in = neg_ff[DIV_STEPS-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                       : {1'b0, {(COEF_W-1){1'b1}}};
      end else if (neg_ff[DIV_STEPS-1]) begin
         quot_in = COEF_W'(-({1'b0, q_fin} + COEF_W'(r_nz)));
      end else begin
         quot_in = {1'b0, q_fin};
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = $signed(quot_ff);

endmodule

@@ design/perspective_plane_address_map_core.sv @@
// top level of the perspective plane address map
//
// Maps one output pixel (req_pixel_u, req_pixel_v) per clock back onto the
// marker plane through a projective map held in eight coefficient registers.
// A pixel transfer happens at a rising edge with start high and busy low;
// busy is always low, so a new pixel may be given in every cycle.
// Coefficients are written over the csr_ port (write enable, index, data);
// the user must write them only while no pixel is in flight, as the block
// does not enforce it; they take effect for later pixels. Each result is
// shown for one cycle with rsp_strobe high. Throughput is one pixel per
// clock. The path runs through three multiply-add stages, the two pipelined
// dividers, one quotient bit per stage for 31 stages, and two output stages.
// Results come out in pixel order and the receiver cannot stall them.
// Reset loads the identity coefficients and clears all valid bits, so no
// result is produced until pixels are given after reset.
module perspective_plane_address_map_core
   import ppam_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [PIX_W-1:0]         req_pixel_u,
   input  logic [PIX_W-1:0]         req_pixel_v,
   output logic                     rsp_strobe,
   output logic                     rsp_inside_res,
   output logic signed [COEF_W-1:0] rsp_plane_x,
   output logic signed [COEF_W-1:0] rsp_plane_y,
   output logic [TEX_W-1:0]         rsp_texture_col,
   output logic [TEX_W-1:0]         rsp_texture_row,
   input  logic                     csr_write_en,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [COEF_W-1:0]        csr_data
);

   coef_set_type             coef_ff;
   prep_type                 prep;
   side_type                 side_ff [DIV_LAT];
   logic signed [COEF_W-1:0] qx, qy;
   side_type                 side_out;
   logic                     inside_in;
   logic                     strobe_ff, inside_ff;
   logic [COEF_W-1:0]        px_ff, py_ff, px_in, py_in;
   logic [TEX_W-1:0]         col_ff, row_ff;

   assign busy = 1'b0;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_XU] <= COEF_W'(65536);
         coef_ff[REG_XV] <= '0;
         coef_ff[REG_X0] <= '0;
         coef_ff[REG_YU] <= '0;
         coef_ff[REG_YV] <= COEF_W'(65536);
         coef_ff[REG_Y0] <= '0;
         coef_ff[REG_DU] <= '0;
         coef_ff[REG_DV] <= '0;
      end else if (csr_write_en) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   ppam_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .pixel_u  (req_pixel_u),
      .pixel_v  (req_pixel_v),
      .coefs    (coef_ff),
      .prep     (prep)
   );

   ppam_div u_div_x (
      .clock (clock),
      .mag   (prep.mag_x),
      .neg   (prep.neg_x),
      .sat   (prep.sat_x),
      .den   (prep.den),
      .quot  (qx)
   );

   ppam_div u_div_y (
      .clock (clock),
      .mag   (prep.mag_y),
      .neg   (prep.neg_y),
      .sat   (prep.sat_y),
      .den   (prep.den),
      .quot  (qy)
   );

   // control delay line alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= prep.side;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign side_out = side_ff[DIV_LAT-1];

   // board rectangle test and texture address
   assign px_in = side_out.den_ok ? COEF_W'(qx) : '0;
   assign py_in = side_out.den_ok ? COEF_W'(qy) : '0;
   assign inside_in = side_out.den_ok && side_out.in_img &&
                      !qx[COEF_W-1] && (qx < $signed(COEF_W'(PLANE_WIDTH) << 16)) &&
                      !qy[COEF_W-1] && (qy < $signed(COEF_W'(PLANE_HEIGHT) << 16));

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      col_ff    <= inside_in ? qx[16 +: TEX_W] : '0;
      row_ff    <= inside_in ? TEX_W'(TEX_W'(PLANE_HEIGHT - 1) - qy[16 +: TEX_W]) : '0;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= side_out.valid;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_inside_res  = inside_ff;
   assign rsp_plane_x     = $signed(px_ff);
   assign rsp_plane_y     = $signed(py_ff);
   assign rsp_texture_col = col_ff;
   assign rsp_texture_row = row_ff;

endmodule
